/* rtl/tun_pkg.sv */
// Package for the triangle unit normal pipeline: field widths, stage counts, side-band type.
// No dependencies; used by rtl/triangle_unit_normal.sv.
`default_nettype none
package tun_pkg;
  localparam int CW     = 12;          // coordinate width
  localparam int EW     = CW + 1;      // edge vector width
  localparam int PW     = 2 * EW;      // edge product width
  localparam int XW     = PW + 1;      // cross component width
  localparam int SQW    = 2 * XW;      // square width
  localparam int NW     = SQW + 2;     // squared length width (even)
  localparam int RW     = NW / 2;      // root width
  localparam int REMW   = RW + 3;      // square-root remainder width
  localparam int FB     = 14;          // output fraction bits
  localparam int QW     = FB + 1;      // quotient magnitude width
  localparam int OW     = FB + 2;      // output component width
  localparam int DW     = RW + 1;      // divider remainder width
  localparam int N_SQRT = RW;          // one root bit per stage
  localparam int N_DIV  = FB + 1;      // integer bit plus fraction bits
  localparam logic [QW-1:0] LIM = QW'(1) << FB;

  typedef struct packed {
    logic [XW-1:0] mx;
    logic [XW-1:0] my;
    logic [XW-1:0] mz;
    logic          sx;
    logic          sy;
    logic          sz;
    logic          degen;
  } side_t;
endpackage
`default_nettype wire

/* rtl/triangle_unit_normal.sv */
// Unit face normal of a triangle, Q1.14 result, fully pipelined.
// 49 register stages, from the edge-vector registers to the output registers.
// One transaction per cycle while the output is not held; most stages are in the per-bit
// square-root (28 stages) and divider (15 stages) pipelines.
// A stall at the output freezes the whole pipeline; no transaction is dropped or repeated.
// Reset (rst, synchronous, active high) clears all stage valid bits; payload is not reset.
// Depends on rtl/tun_pkg.sv.
`default_nettype none
module triangle_unit_normal (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tun_pkg::CW-1:0]        ax,
  input  wire logic [tun_pkg::CW-1:0]        ay,
  input  wire logic [tun_pkg::CW-1:0]        az,
  input  wire logic [tun_pkg::CW-1:0]        bx,
  input  wire logic [tun_pkg::CW-1:0]        by_coord,
  input  wire logic [tun_pkg::CW-1:0]        bz,
  input  wire logic [tun_pkg::CW-1:0]        cx,
  input  wire logic [tun_pkg::CW-1:0]        cy,
  input  wire logic [tun_pkg::CW-1:0]        cz,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [tun_pkg::OW-1:0]      nx,
  output logic signed [tun_pkg::OW-1:0]      ny,
  output logic signed [tun_pkg::OW-1:0]      nz,
  output logic                               degenerate
);
  localparam int EW = tun_pkg::EW;
  localparam int PW = tun_pkg::PW;
  localparam int XW = tun_pkg::XW;
  localparam int SQW = tun_pkg::SQW;
  localparam int NW = tun_pkg::NW;
  localparam int RW = tun_pkg::RW;
  localparam int REMW = tun_pkg::REMW;
  localparam int QW = tun_pkg::QW;
  localparam int OW = tun_pkg::OW;
  localparam int DW = tun_pkg::DW;
  localparam int N_SQRT = tun_pkg::N_SQRT;
  localparam int N_DIV = tun_pkg::N_DIV;

  // Whole pipeline moves together; it only halts when the output is held.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: edge vectors u = a - c, v = b - c
  logic signed [EW-1:0] u0, u1, u2, v0, v1, v2;
  logic vld_e;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_e <= 1'b0;
    end else if (adv) begin
      vld_e <= in_valid;
    end
    if (adv) begin
      u0 <= {ax[tun_pkg::CW-1], ax} - {cx[tun_pkg::CW-1], cx};
      u1 <= {ay[tun_pkg::CW-1], ay} - {cy[tun_pkg::CW-1], cy};
      u2 <= {az[tun_pkg::CW-1], az} - {cz[tun_pkg::CW-1], cz};
      v0 <= {bx[tun_pkg::CW-1], bx} - {cx[tun_pkg::CW-1], cx};
      v1 <= {by_coord[tun_pkg::CW-1], by_coord} - {cy[tun_pkg::CW-1], cy};
      v2 <= {bz[tun_pkg::CW-1], bz} - {cz[tun_pkg::CW-1], cz};
    end
  end

  // Stage 2: edge products m_a to m_f
  logic signed [PW-1:0] m_a, m_b, m_c, m_d, m_e, m_f;
  logic vld_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (adv) begin
      vld_p <= vld_e;
    end
    if (adv) begin
      m_a <= PW'(u1) * PW'(v2);
      m_b <= PW'(u2) * PW'(v1);
      m_c <= PW'(u2) * PW'(v0);
      m_d <= PW'(u0) * PW'(v2);
      m_e <= PW'(u0) * PW'(v1);
      m_f <= PW'(u1) * PW'(v0);
    end
  end

  // Stage 3: cross product split into sign and magnitude, plus degenerate flag
  logic signed [XW-1:0] x_c, y_c, z_c;
  assign x_c = XW'(m_a) - XW'(m_b);
  assign y_c = XW'(m_c) - XW'(m_d);
  assign z_c = XW'(m_e) - XW'(m_f);

  tun_pkg::side_t side_c;
  logic vld_c;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (adv) begin
      vld_c <= vld_p;
    end
    if (adv) begin
      side_c.mx    <= x_c[XW-1] ? XW'(-x_c) : XW'(x_c);
      side_c.my    <= y_c[XW-1] ? XW'(-y_c) : XW'(y_c);
      side_c.mz    <= z_c[XW-1] ? XW'(-z_c) : XW'(z_c);
      side_c.sx    <= x_c[XW-1];
      side_c.sy    <= y_c[XW-1];
      side_c.sz    <= z_c[XW-1];
      side_c.degen <= (x_c == '0) && (y_c == '0) && (z_c == '0);
    end
  end

  // Stage 4: squares
  logic [SQW-1:0] q_x, q_y, q_z;
  tun_pkg::side_t side_s;
  logic vld_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= 1'b0;
    end else if (adv) begin
      vld_s <= vld_c;
    end
    if (adv) begin
      q_x    <= SQW'(side_c.mx) * SQW'(side_c.mx);
      q_y    <= SQW'(side_c.my) * SQW'(side_c.my);
      q_z    <= SQW'(side_c.mz) * SQW'(side_c.mz);
      side_s <= side_c;
    end
  end

  // Stage 5: squared length
  logic [NW-1:0] n_sum;
  tun_pkg::side_t side_n;
  logic vld_n;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_n <= 1'b0;
    end else if (adv) begin
      vld_n <= vld_s;
    end
    if (adv) begin
      n_sum  <= NW'(q_x) + NW'(q_y) + NW'(q_z);
      side_n <= side_s;
    end
  end

  // Square root, one result bit per stage, two radicand bits consumed each time
  logic [REMW-1:0]  sq_rem   [N_SQRT];
  logic [RW-1:0]    sq_root  [N_SQRT];
  logic [NW-1:0]    sq_rad   [N_SQRT];
  tun_pkg::side_t   sq_side  [N_SQRT];
  logic             sq_vld   [N_SQRT];
  logic [REMW-1:0]  sqi_rem  [N_SQRT];
  logic [RW-1:0]    sqi_root [N_SQRT];
  logic [NW-1:0]    sqi_rad  [N_SQRT];
  tun_pkg::side_t   sqi_side [N_SQRT];
  logic             sqi_vld  [N_SQRT];

  for (genvar k = 0; k < N_SQRT; k++) begin : g_sqrt
    logic [REMW-1:0] rem_t;
    logic [REMW-1:0] trial;
    if (k == 0) begin : g_first
      assign sqi_rem[k]  = '0;
      assign sqi_root[k] = '0;
      assign sqi_rad[k]  = n_sum;
      assign sqi_side[k] = side_n;
      assign sqi_vld[k]  = vld_n;
    end else begin : g_next
      assign sqi_rem[k]  = sq_rem[k-1];
      assign sqi_root[k] = sq_root[k-1];
      assign sqi_rad[k]  = sq_rad[k-1];
      assign sqi_side[k] = sq_side[k-1];
      assign sqi_vld[k]  = sq_vld[k-1];
    end
    assign rem_t = {sqi_rem[k][REMW-3:0], sqi_rad[k][NW-1:NW-2]};
    assign trial = {{(REMW-RW-2){1'b0}}, sqi_root[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (adv) begin
        sq_vld[k] <= sqi_vld[k];
      end
      if (adv) begin
        if (rem_t >= trial) begin
          sq_rem[k]  <= rem_t - trial;
          sq_root[k] <= {sqi_root[k][RW-2:0], 1'b1};
        end else begin
          sq_rem[k]  <= rem_t;
          sq_root[k] <= {sqi_root[k][RW-2:0], 1'b0};
        end
        sq_rad[k]  <= {sqi_rad[k][NW-3:0], 2'b00};
        sq_side[k] <= sqi_side[k];
      end
    end
  end

  // Restoring divider: |c| * 2^14 / root, one quotient bit per stage, three lanes
  logic [DW-1:0]  dv_r   [N_DIV][3];
  logic [QW-1:0]  dv_q   [N_DIV][3];
  logic [RW-1:0]  dv_s   [N_DIV];
  tun_pkg::side_t dv_side[N_DIV];
  logic           dv_vld [N_DIV];

  logic [DW-1:0] mag0 [3];
  assign mag0[0] = DW'(sq_side[N_SQRT-1].mx);
  assign mag0[1] = DW'(sq_side[N_SQRT-1].my);
  assign mag0[2] = DW'(sq_side[N_SQRT-1].mz);

  for (genvar j = 0; j < N_DIV; j++) begin : g_div
    logic [RW-1:0] s_in;
    logic          v_in;
    tun_pkg::side_t sd_in;
    if (j == 0) begin : g_first
      assign s_in  = sq_root[N_SQRT-1];
      assign v_in  = sq_vld[N_SQRT-1];
      assign sd_in = sq_side[N_SQRT-1];
    end else begin : g_next
      assign s_in  = dv_s[j-1];
      assign v_in  = dv_vld[j-1];
      assign sd_in = dv_side[j-1];
    end
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [DW-1:0] rs;
      logic [QW-1:0] q_in;
      logic          ge;
      if (j == 0) begin : g_first
        assign rs   = mag0[c];
        assign q_in = '0;
      end else begin : g_next
        assign rs   = {dv_r[j-1][c][DW-2:0], 1'b0};
        assign q_in = dv_q[j-1][c];
      end
      assign ge = rs >= DW'(s_in);
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_r[j][c] <= ge ? rs - DW'(s_in) : rs;
          dv_q[j][c] <= {q_in[QW-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else if (adv) begin
        dv_vld[j] <= v_in;
      end
      if (adv) begin
        dv_s[j]    <= s_in;
        dv_side[j] <= sd_in;
      end
    end
  end

  // Output stage: clamp guard, sign, degenerate override
  function automatic logic [OW-1:0] finish(input logic [QW-1:0] q, input logic neg,
                                           input logic degen);
    logic [QW-1:0] qc;
    logic [OW-1:0] mag;
    qc  = (q > tun_pkg::LIM) ? tun_pkg::LIM : q;
    mag = {1'b0, qc};
    if (degen) begin
      return '0;
    end
    return neg ? OW'(-mag) : mag;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[N_DIV-1];
    end
    if (adv) begin
      nx <= finish(dv_q[N_DIV-1][0], dv_side[N_DIV-1].sx, dv_side[N_DIV-1].degen);
      ny <= finish(dv_q[N_DIV-1][1], dv_side[N_DIV-1].sy, dv_side[N_DIV-1].degen);
      nz <= finish(dv_q[N_DIV-1][2], dv_side[N_DIV-1].sz, dv_side[N_DIV-1].degen);
      degenerate <= dv_side[N_DIV-1].degen;
    end
  end

  // Checks
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> (nx == '0) && (ny == '0) && (nz == '0))
    else $error("degenerate result with non-zero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(nx) <= $signed(OW'(tun_pkg::LIM))) &&
                  ($signed(nx) >= -$signed(OW'(tun_pkg::LIM))) &&
                  ($signed(nz) <= $signed(OW'(tun_pkg::LIM))) &&
                  ($signed(nz) >= -$signed(OW'(tun_pkg::LIM))))
    else $error("normal component out of range");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dv_vld[N_DIV-1]) && $stable(sq_vld[0]))
    else $error("pipeline moved while output held");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    dv_vld[0] && !dv_side[0].degen |-> dv_q[0][0] <= QW'(1))
    else $error("integer quotient bit exceeds one");
endmodule
`default_nettype wire
